[rtl/pcm_sample_normalizer_macros.svh]
// Assertion macros for the PCM sample normalizer.
// Included by RTL files that carry concurrent assertions; depends on nothing.
`ifndef PCM_SAMPLE_NORMALIZER_MACROS_SVH
`define PCM_SAMPLE_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled while the synchronous active-low reset is asserted.
`define PSN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the synchronous active-low reset is asserted.
`define PSN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pcm_norm_pkg.sv]
// Shared constants, codes and helper functions for the PCM sample normalizer.
// Standalone package; no dependencies.
`default_nettype none

package pcm_norm_pkg;

    // Fraction bits of the normalized result (Q2.30 by default).
    localparam int OUT_FRAC_BITS = 30;

    // Integer magnitude below full scale fits in at most 31 bits.
    localparam int MAG_W = 31;
    // Scaled magnitude times two, plus one integer bit of headroom.
    localparam int PAT_W = OUT_FRAC_BITS + 2;
    // Smallest repeat length of the reciprocal pattern (one-byte samples).
    localparam int MIN_K = 7;
    localparam int MAX_TERMS = (OUT_FRAC_BITS + 1) / MIN_K + 1;

    // Repeat lengths for 1, 2, 3 and 4 byte samples (sample bits minus one).
    localparam int K_BYTES1 = 7;
    localparam int K_BYTES2 = 15;
    localparam int K_BYTES3 = 23;
    localparam int K_BYTES4 = 31;

    // IEEE single: exponent bias plus mantissa width, and the widest useful right shift.
    localparam int FLT_SHIFT_BASE = 150;
    localparam int FLT_MAX_RSHIFT = 25;
    localparam int FSH_W = 9;
    localparam logic [7:0] FLT_EXP_MAX = 8'hFF;
    localparam logic [7:0] FLT_EXP_ONE = 8'd127;

    // Plus and minus one in the output format.
    localparam logic signed [31:0] NORM_MAX = 32'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [31:0] NORM_MIN = -NORM_MAX;

    // Sample kind codes.
    localparam logic [1:0] KIND_SIGNED   = 2'd0;
    localparam logic [1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [1:0] KIND_FLOAT    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_KIND   = 2'd0;
    localparam logic [1:0] REG_BYTES  = 2'd1;
    localparam logic [1:0] REG_ENDIAN = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [1:0] KIND_RESET  = KIND_SIGNED;
    localparam logic [2:0] BYTES_RESET = 3'd2;

    // Conversion path chosen for a sample.
    typedef enum logic [1:0] {
        PATH_NONE,
        PATH_INT,
        PATH_FLOAT
    } t_path;

    // Class of a float sample.
    typedef enum logic [1:0] {
        FCLS_ZERO,
        FCLS_SAT,
        FCLS_NORM
    } t_fcls;

    // Reorder the first n bytes of a word into an integer, zero above n bytes.
    function automatic logic [31:0] gather_bytes(input logic [31:0] word,
                                                 input logic [2:0]  n,
                                                 input logic        be);
        logic [31:0] acc;
        logic [2:0]  pos;
        acc = '0;
        pos = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < n) begin
                pos = be ? (n - 3'd1 - 3'(i)) : 3'(i);
                acc[8*pos[1:0] +: 8] = word[8*i +: 8];
            end
        end
        return acc;
    endfunction

    // floor(2 * mag * 2^OUT_FRAC_BITS / (2^k - 1)) for mag < 2^k. The quotient is
    // mag repeated every k bits, so the blocks never overlap and OR equals sum.
    function automatic logic [PAT_W-1:0] repeat_pattern(input logic [MAG_W-1:0] mag,
                                                        input int k);
        logic [63:0] acc;
        logic [63:0] m64;
        int          s;
        acc = '0;
        m64 = 64'(mag);
        s   = 0;
        for (int j = 1; j <= MAX_TERMS; j++) begin
            s = OUT_FRAC_BITS + 1 - j * k;
            if (s >= 0) begin
                acc = acc | (m64 << s);
            end else if (-s < 64) begin
                acc = acc | (m64 >> (-s));
            end
        end
        return acc[PAT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/pcm_sample_normalizer.sv]
// PCM sample normalizer: raw 1 to 4 byte sample word to signed Q2.30, four-stage pipeline.
// Depends on pcm_norm_pkg and pcm_sample_normalizer_macros.svh.
`default_nettype none
`include "pcm_sample_normalizer_macros.svh"

// A sample is taken at every rising edge where start is high; busy never rises, so one
// transaction per clock is sustained. Each result appears on o_norm_value and
// o_format_ok after passing through the register stages below, marked for exactly
// one cycle by o_result_valid; results come out in input order and cannot be held
// off. There are four register stages: byte reorder, sign and magnitude decode,
// reciprocal pattern or float shift, and rounding with clamp. Integer samples are
// divided by 2^(n-1)-1 through a repeating bit pattern, so no multiplier is used.
// Configuration writes are always accepted (o_cfg_ready is high) and must only be
// issued while no sample is in flight. An unsupported format gives zero with
// o_format_ok low.
module pcm_sample_normalizer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // Sample command channel
    input  wire                start,
    output logic               busy,
    input  wire  [31:0]        i_raw_word,
    // Configuration write channel
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [2:0]         i_cfg_data,
    // Result strobe and payload
    output logic               o_result_valid,
    output logic signed [31:0] o_norm_value,
    output logic               o_format_ok
);
    import pcm_norm_pkg::*;

    // Configuration registers
    logic [1:0] r_sample_kind;
    logic [2:0] r_sample_bytes;
    logic       r_big_endian;

    // Stage valid bits
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;

    // Stage 1 payload
    logic [31:0]      r_s1_raw;
    t_path            r_s1_path;
    // Stage 2 payload
    t_path            r_s2_path;
    logic             r_s2_neg;
    logic             r_s2_full;
    logic [MAG_W-1:0] r_s2_mag;
    t_fcls            r_s2_fcls;
    logic [23:0]      r_s2_fman;
    logic signed [FSH_W-1:0] r_s2_fsh;
    // Stage 3 payload
    t_path            r_s3_path;
    logic             r_s3_neg;
    logic             r_s3_full;
    logic [PAT_W-1:0] r_s3_pat;
    t_fcls            r_s3_fcls;
    logic [31:0]      r_s3_fmag;

    // Next values
    logic [31:0]      n_s1_raw;
    t_path            n_s1_path;
    logic             n_s2_neg;
    logic             n_s2_full;
    logic [MAG_W-1:0] n_s2_mag;
    t_fcls            n_s2_fcls;
    logic signed [FSH_W-1:0] n_s2_fsh;
    logic [PAT_W-1:0] n_s3_pat;
    logic [31:0]      n_s3_fmag;
    logic signed [31:0] n_norm_value;

    // Stage 2 helpers
    logic             int_top;
    logic [MAG_W-1:0] int_low;
    logic [MAG_W-1:0] int_mask;
    logic [7:0]       flt_exp;
    logic [22:0]      flt_man;
    // Stage 3 helpers
    logic [FSH_W-1:0] flt_lsh;
    logic [31:0]      flt_trunc;
    // Stage 4 helpers
    logic [PAT_W-1:0] int_q;
    logic [31:0]      out_mag;

    logic accept;

    // The pipeline never stalls, so a sample is taken whenever start is high.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_kind  <= KIND_RESET;
            r_sample_bytes <= BYTES_RESET;
            r_big_endian   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KIND:   r_sample_kind  <= i_cfg_data[1:0];
                REG_BYTES:  r_sample_bytes <= i_cfg_data;
                REG_ENDIAN: r_big_endian   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Stage 1: byte reorder and format check.
    always_comb begin
        n_s1_raw  = gather_bytes(i_raw_word, r_sample_bytes, r_big_endian);
        n_s1_path = PATH_NONE;
        if (r_sample_bytes >= 3'd1 && r_sample_bytes <= 3'd4) begin
            if (r_sample_kind == KIND_SIGNED || r_sample_kind == KIND_UNSIGNED) begin
                n_s1_path = PATH_INT;
            end else if (r_sample_kind == KIND_FLOAT && r_sample_bytes == 3'd4) begin
                n_s1_path = PATH_FLOAT;
            end
        end
    end

    // Stage 2: integer sign and magnitude, float classification and shift amount.
    always_comb begin
        unique case (r_sample_bytes)
            3'd1: begin
                int_top  = r_s1_raw[7];
                int_low  = MAG_W'(r_s1_raw[6:0]);
                int_mask = MAG_W'(7'h7F);
            end
            3'd2: begin
                int_top  = r_s1_raw[15];
                int_low  = MAG_W'(r_s1_raw[14:0]);
                int_mask = MAG_W'(15'h7FFF);
            end
            3'd3: begin
                int_top  = r_s1_raw[23];
                int_low  = MAG_W'(r_s1_raw[22:0]);
                int_mask = MAG_W'(23'h7F_FFFF);
            end
            default: begin
                int_top  = r_s1_raw[31];
                int_low  = r_s1_raw[30:0];
                int_mask = {MAG_W{1'b1}};
            end
        endcase

        flt_exp = r_s1_raw[30:23];
        flt_man = r_s1_raw[22:0];

        if (r_s1_path == PATH_FLOAT) begin
            n_s2_neg = r_s1_raw[31];
        end else begin
            // Unsigned samples below the midpoint are negative.
            n_s2_neg = int_top ^ (r_sample_kind == KIND_UNSIGNED);
        end
        // Full scale negative exceeds minus one and is clamped later.
        n_s2_full = n_s2_neg && (int_low == '0);
        n_s2_mag  = n_s2_neg ? ((MAG_W'(0) - int_low) & int_mask) : int_low;

        if (flt_exp == FLT_EXP_MAX) begin
            n_s2_fcls = (flt_man != '0) ? FCLS_ZERO : FCLS_SAT;
        end else if (flt_exp == '0) begin
            n_s2_fcls = FCLS_ZERO;
        end else if (flt_exp >= FLT_EXP_ONE) begin
            n_s2_fcls = FCLS_SAT;
        end else begin
            n_s2_fcls = FCLS_NORM;
        end
        n_s2_fsh = FSH_W'(FLT_SHIFT_BASE - OUT_FRAC_BITS - int'(flt_exp));
    end

    // Stage 3: reciprocal pattern for integers, rounded shift for floats.
    always_comb begin
        unique case (r_sample_bytes)
            3'd1:    n_s3_pat = repeat_pattern(r_s2_mag, K_BYTES1);
            3'd2:    n_s3_pat = repeat_pattern(r_s2_mag, K_BYTES2);
            3'd3:    n_s3_pat = repeat_pattern(r_s2_mag, K_BYTES3);
            default: n_s3_pat = repeat_pattern(r_s2_mag, K_BYTES4);
        endcase

        flt_lsh   = FSH_W'(-r_s2_fsh);
        flt_trunc = '0;
        if (r_s2_fsh <= 0) begin
            n_s3_fmag = 32'(r_s2_fman) << flt_lsh;
        end else if (r_s2_fsh > FSH_W'(FLT_MAX_RSHIFT)) begin
            n_s3_fmag = '0;
        end else begin
            // Keep one extra bit, then round half up.
            flt_trunc = 32'(r_s2_fman) >> (r_s2_fsh - FSH_W'(1));
            n_s3_fmag = (flt_trunc + 32'd1) >> 1;
        end
    end

    // Stage 4: round, clamp and apply the sign.
    always_comb begin
        int_q = (r_s3_pat + PAT_W'(1)) >> 1;
        unique case (r_s3_path)
            PATH_INT: begin
                out_mag = r_s3_full ? 32'(NORM_MAX) : 32'(int_q);
            end
            PATH_FLOAT: begin
                unique case (r_s3_fcls)
                    FCLS_SAT:  out_mag = 32'(NORM_MAX);
                    FCLS_NORM: out_mag = (r_s3_fmag > 32'(NORM_MAX)) ?
                                         32'(NORM_MAX) : r_s3_fmag;
                    default:   out_mag = '0;
                endcase
            end
            default: out_mag = '0;
        endcase
        n_norm_value = r_s3_neg ? -$signed(out_mag) : $signed(out_mag);
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_s1_valid     <= accept;
            r_s2_valid     <= r_s1_valid;
            r_s3_valid     <= r_s2_valid;
            o_result_valid <= r_s3_valid;
        end
    end

    // Payload registers load only when a sample is moving into their stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_raw  <= n_s1_raw;
            r_s1_path <= n_s1_path;
        end
        if (r_s1_valid) begin
            r_s2_path <= r_s1_path;
            r_s2_neg  <= n_s2_neg;
            r_s2_full <= n_s2_full;
            r_s2_mag  <= n_s2_mag;
            r_s2_fcls <= n_s2_fcls;
            r_s2_fman <= {1'b1, flt_man};
            r_s2_fsh  <= n_s2_fsh;
        end
        if (r_s2_valid) begin
            r_s3_path <= r_s2_path;
            r_s3_neg  <= r_s2_neg;
            r_s3_full <= r_s2_full;
            r_s3_pat  <= n_s3_pat;
            r_s3_fcls <= r_s2_fcls;
            r_s3_fmag <= n_s3_fmag;
        end
        if (r_s3_valid) begin
            o_norm_value <= n_norm_value;
            o_format_ok  <= (r_s3_path != PATH_NONE);
        end
    end

    // Every result traces back to a sample taken while start was high.
    `PSN_ASSERT_NOW(a_result_has_source, i_clk, i_rst_n, o_result_valid, $past(start, 4), "result without a sample four cycles earlier")
    // An unsupported format never leaks a nonzero value.
    `PSN_ASSERT_NOW(a_unsupported_is_zero, i_clk, i_rst_n, o_result_valid && !o_format_ok, o_norm_value == '0, "unsupported format gave a nonzero value")
    // Results stay within plus and minus one.
    `PSN_ASSERT_NOW(a_result_in_range, i_clk, i_rst_n, o_result_valid, o_norm_value <= NORM_MAX && o_norm_value >= NORM_MIN, "normalized value outside plus or minus one")
    // The last pipeline stage always drains into the result strobe.
    `PSN_ASSERT_NEXT(a_stage_drains, i_clk, i_rst_n, r_s3_valid, o_result_valid, "sample lost between the last stage and the output")

endmodule

`default_nettype wire
